// ----- rtl/jbp_pkg.sv -----
// Shared types and constants for the JPEG bit packer with byte stuffing.
`timescale 1ns / 1ps
`default_nettype none

package jbp_pkg;

  // Longest code a single word may append.
  localparam int unsigned MAX_CODE_LEN = 16;
  localparam int unsigned CODE_LEN_W   = 5;
  localparam int unsigned CODE_W       = 16;
  localparam int unsigned BYTE_W       = 8;
  // Pending bits between words stay below one byte.
  localparam int unsigned PEND_W       = 3;

  localparam logic [BYTE_W-1:0] STUFF_TRIGGER = 8'hFF;
  localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;

  // Command codes on the input channel.
  localparam logic CMD_APPEND  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Queue between the packing front and the byte-emitting back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = QUEUE_PTR_W + 1;

  // One or two whole data bytes produced by one append word.
  typedef struct packed {
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic              two_bytes;
  } jbp_entry_t;

  // Push request from the front to the queue.
  typedef struct packed {
    logic       valid;
    jbp_entry_t entry;
  } jbp_push_t;

endpackage

`default_nettype wire

// ----- rtl/jpeg_bit_packer_byte_stuffing.sv -----
// Top level of the JPEG entropy bit packer with 0xFF/0x00 byte stuffing.
//
// Input channel: each word is either an append (in_command low) carrying a
// right-aligned code in in_code_bits of in_code_length bits (lengths above
// sixteen count as sixteen), or a restart (in_command high) that clears the
// accumulator and the pending bit count. A word is taken at a rising edge
// where in_valid is high and in_stall is low.
// Output channel: one word per stream byte, most significant bits first.
// out_is_stuffed marks the 0x00 inserted after a 0xFF data byte, and
// out_last_of_run marks the final byte caused by one input word. Words that
// complete no byte produce no output.
// Timing: the first byte of an input word passes through the queue and the
// output register before it is presented. The back end sends one byte per
// cycle while out_stall is low, and one word yields up to four bytes there
// (two data bytes, each possibly followed by a stuffed zero); the front takes
// one word per cycle into a four-entry queue and raises in_stall only when
// that queue is full.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and clears the accumulator. When the receiver asserts out_stall the output
// word holds, the back end waits, and the queue absorbs further input.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_bit_packer_byte_stuffing import jbp_pkg::*; #(
  parameter int unsigned ACC_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_command,
  input  wire logic [CODE_W-1:0]     in_code_bits,
  input  wire logic [CODE_LEN_W-1:0] in_code_length,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [BYTE_W-1:0]          out_out_byte,
  output logic                       out_is_stuffed,
  output logic                       out_last_of_run
);

  jbp_push_t  push;
  jbp_entry_t head;
  logic       q_full;
  logic       head_valid;
  logic       pop;
  logic       accept;

  // The front never has to wait on anything but room in the queue.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  jbp_front #(
    .ACC_BITS(ACC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .code_bits  (in_code_bits),
    .code_length(in_code_length),
    .push       (push)
  );

  jbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head)
  );

  jbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_out_byte),
    .out_is_stuffed (out_is_stuffed),
    .out_last_of_run(out_last_of_run)
  );

endmodule

`default_nettype wire

// ----- rtl/jbp_front.sv -----
// Packing front: merges codes into the accumulator and splits off whole bytes.
`timescale 1ns / 1ps
`default_nettype none

module jbp_front import jbp_pkg::*; #(
  parameter int unsigned ACC_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  command,
  input  wire logic [CODE_W-1:0]     code_bits,
  input  wire logic [CODE_LEN_W-1:0] code_length,
  output jbp_push_t                  push
);

  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [PEND_W-1:0]     count_r, count_nxt;

  logic [CODE_LEN_W-1:0] len_sat;
  logic [CODE_W:0]       mask_ext;
  logic [CODE_W-1:0]     code_masked;
  logic [CODE_LEN_W-1:0] total;
  logic [6:0]            shift_amt;
  logic [ACC_BITS-1:0]   code_placed;
  logic [ACC_BITS-1:0]   acc_or;
  logic [1:0]            nbytes;

  always_comb begin
    len_sat = (code_length > CODE_LEN_W'(MAX_CODE_LEN)) ?
              CODE_LEN_W'(MAX_CODE_LEN) : code_length;
    mask_ext    = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);
    code_masked = code_bits & mask_ext[CODE_W-1:0];
    total       = {{(CODE_LEN_W-PEND_W){1'b0}}, count_r} + len_sat;
    // Drop the code in just below the pending bits: its lowest bit lands at
    // ACC_BITS minus the new total.
    shift_amt   = 7'(ACC_BITS) - {2'b00, total};
    code_placed = {{(ACC_BITS-CODE_W){1'b0}}, code_masked} << shift_amt;
    acc_or      = acc_r | code_placed;
    nbytes      = total[PEND_W+1:PEND_W];

    push.valid           = accept && (command == CMD_APPEND) && (nbytes != 2'd0);
    push.entry.byte0     = acc_or[ACC_BITS-1 -: BYTE_W];
    push.entry.byte1     = acc_or[ACC_BITS-1-BYTE_W -: BYTE_W];
    push.entry.two_bytes = nbytes[1];

    acc_nxt   = acc_r;
    count_nxt = count_r;
    if (accept) begin
      if (command == CMD_RESTART) begin
        acc_nxt   = '0;
        count_nxt = '0;
      end else begin
        acc_nxt   = acc_or << {nbytes, 3'b000};
        count_nxt = total[PEND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      count_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jbp_queue.sv -----
// Short queue of packed byte groups between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module jbp_queue import jbp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire jbp_push_t  push,
  input  wire logic       pop,
  output logic            full,
  output logic            head_valid,
  output jbp_entry_t      head
);

  jbp_entry_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push;
  logic                   do_pop;

  always_comb begin
    full       = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
    head_valid = (count_r != '0);
    head       = mem_r[rd_ptr_r];
    do_push    = push.valid && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jbp_back.sv -----
// Emitting back: sends queued bytes one per cycle while out_stall is low and inserts stuffed zeros.
`timescale 1ns / 1ps
`default_nettype none

module jbp_back import jbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire jbp_entry_t        head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_is_stuffed,
  output logic                   out_last_of_run
);

  typedef enum logic [1:0] {
    PH_BYTE0,
    PH_STUFF0,
    PH_BYTE1,
    PH_STUFF1
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_stuffed_r, out_stuffed_nxt;
  logic              out_last_r, out_last_nxt;
  logic              load;
  logic              emit;
  logic              is_last;
  phase_t            phase_after;

  always_comb begin
    load = !out_valid_r || !out_stall;
    emit = load && head_valid;

    out_byte_nxt    = STUFF_BYTE;
    out_stuffed_nxt = 1'b0;
    is_last         = 1'b1;
    phase_after     = PH_BYTE0;
    case (phase_r)
      PH_BYTE0: begin
        out_byte_nxt = head.byte0;
        if (head.byte0 == STUFF_TRIGGER) begin
          is_last     = 1'b0;
          phase_after = PH_STUFF0;
        end else if (head.two_bytes) begin
          is_last     = 1'b0;
          phase_after = PH_BYTE1;
        end
      end
      PH_STUFF0: begin
        out_stuffed_nxt = 1'b1;
        if (head.two_bytes) begin
          is_last     = 1'b0;
          phase_after = PH_BYTE1;
        end
      end
      PH_BYTE1: begin
        out_byte_nxt = head.byte1;
        if (head.byte1 == STUFF_TRIGGER) begin
          is_last     = 1'b0;
          phase_after = PH_STUFF1;
        end
      end
      PH_STUFF1: begin
        out_stuffed_nxt = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    out_last_nxt = is_last;

    pop           = emit && is_last;
    phase_nxt     = emit ? phase_after : phase_r;
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BYTE0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_byte_r    <= out_byte_nxt;
      out_stuffed_r <= out_stuffed_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_is_stuffed  = out_stuffed_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/jbp_checker.sv -----
// Port-level checks for the bit packer and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module jbp_checker import jbp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [BYTE_W-1:0] out_out_byte,
  input wire logic              out_is_stuffed,
  input wire logic              out_last_of_run
);

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled output word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte)
      && $stable(out_is_stuffed) && $stable(out_last_of_run))
    else $error("stalled output word changed");

  // A stuffed word is always a zero byte.
  a_stuff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_stuffed |-> out_out_byte == STUFF_BYTE)
    else $error("stuffed word is not zero");

  // A 0xFF data byte never ends a run, and its stuffed zero follows at once.
  a_stuff_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_is_stuffed && out_out_byte == STUFF_TRIGGER
      |-> !out_last_of_run ##1 (out_valid && out_is_stuffed))
    else $error("0xFF byte not followed by stuffed zero");

endmodule

bind jpeg_bit_packer_byte_stuffing jbp_checker u_jbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_out_byte   (out_out_byte),
  .out_is_stuffed (out_is_stuffed),
  .out_last_of_run(out_last_of_run)
);

`default_nettype wire

// ----- tb/jbp_stream_scoreboard.sv -----
// Scoreboard that predicts and checks the byte stream of the JPEG bit packer.
`timescale 1ns / 1ps

module jbp_stream_scoreboard import jbp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic                  in_command,
  input  wire logic [CODE_W-1:0]     in_code_bits,
  input  wire logic [CODE_LEN_W-1:0] in_code_length,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [BYTE_W-1:0]     out_out_byte,
  input  wire logic                  out_is_stuffed,
  input  wire logic                  out_last_of_run,
  output int unsigned                mismatch_count,
  output int unsigned                bytes_awaited,
  output int unsigned                bytes_checked,
  output int unsigned                stuffed_checked
);

  localparam int unsigned ACC_W = 32;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              stuffed;
    logic              last;
  } stream_byte_t;

  stream_byte_t      expected_bytes[$];
  logic [ACC_W-1:0]  acc_bits;
  logic [4:0]        pend_count;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endtask

  // Packs one word into the accumulator and queues every byte it completes.
  task automatic pack_word(input logic cmd, input logic [CODE_W-1:0] value,
                           input logic [CODE_LEN_W-1:0] len_in);
    logic [CODE_LEN_W-1:0] len;
    logic [ACC_W-1:0]      masked;
    logic [BYTE_W-1:0]     top_byte;
    stream_byte_t          tail;
    int                    first;
    first = expected_bytes.size();
    if (cmd == CMD_RESTART) begin
      acc_bits   = '0;
      pend_count = '0;
    end else begin
      len = (len_in > MAX_CODE_LEN) ? CODE_LEN_W'(MAX_CODE_LEN) : len_in;
      if (len != 0) begin
        masked     = ACC_W'(value) & ((ACC_W'(1) << len) - ACC_W'(1));
        acc_bits   = acc_bits | (masked << (ACC_W - len - pend_count));
        pend_count = pend_count + len;
      end
      while (pend_count >= BYTE_W) begin
        top_byte = acc_bits[ACC_W-1 -: BYTE_W];
        expected_bytes.push_back('{data: top_byte, stuffed: 1'b0, last: 1'b0});
        if (top_byte == STUFF_TRIGGER) begin
          expected_bytes.push_back('{data: STUFF_BYTE, stuffed: 1'b1, last: 1'b0});
        end
        acc_bits   = acc_bits << BYTE_W;
        pend_count = pend_count - 5'(BYTE_W);
      end
      if (expected_bytes.size() > first) begin
        tail      = expected_bytes.pop_back();
        tail.last = 1'b1;
        expected_bytes.push_back(tail);
      end
    end
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      acc_bits   = '0;
      pend_count = '0;
    end else begin
      // A byte taken at this edge can never stem from a word taken at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h stuffed %0b last %0b",
                                  out_out_byte, out_is_stuffed, out_last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (want.stuffed) stuffed_checked++;
          if (want.data !== out_out_byte || want.stuffed !== out_is_stuffed ||
              want.last !== out_last_of_run) begin
            flag_mismatch($sformatf(
              "byte %0d: expected %02h stuffed %0b last %0b, got %02h stuffed %0b last %0b",
              bytes_checked, want.data, want.stuffed, want.last,
              out_out_byte, out_is_stuffed, out_last_of_run));
          end
        end
      end
      if (in_valid && !in_stall) begin
        pack_word(in_command, in_code_bits, in_code_length);
      end
    end
    bytes_awaited <= expected_bytes.size();
  end

endmodule

// ----- tb/jpeg_bit_packer_byte_stuffing_tb.sv -----
// Testbench top for the JPEG bit packer: stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module jpeg_bit_packer_byte_stuffing_tb;
  import jbp_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_APPEND;
  logic [CODE_W-1:0]     in_code_bits = '0;
  logic [CODE_LEN_W-1:0] in_code_length = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_out_byte;
  logic                  out_is_stuffed;
  logic                  out_last_of_run;

  int unsigned mismatch_count;
  int unsigned bytes_awaited;
  int unsigned bytes_checked;
  int unsigned stuffed_checked;

  // Controls shared between the sender and the receiver process.
  // quiet_phase: neither side idles. back_to_back: the sender leaves no gaps.
  // rx_hold_cycles: when nonzero, the receiver stalls for that many cycles.
  logic        quiet_phase = 1'b0;
  logic        back_to_back = 1'b0;
  int unsigned rx_hold_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned restarts_sent = 0;

  jpeg_bit_packer_byte_stuffing u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_code_bits    (in_code_bits),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_is_stuffed  (out_is_stuffed),
    .out_last_of_run (out_last_of_run)
  );

  // The scoreboard watches both channels and predicts the stream on its own.
  jbp_stream_scoreboard u_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_code_bits    (in_code_bits),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_is_stuffed  (out_is_stuffed),
    .out_last_of_run (out_last_of_run),
    .mismatch_count  (mismatch_count),
    .bytes_awaited   (bytes_awaited),
    .bytes_checked   (bytes_checked),
    .stuffed_checked (stuffed_checked)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle lengths are mostly zero or short, with an occasional long one so that
  // gaps land on every phase of the packer's work.
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // Offers one word from a falling edge, holds it until it is taken, then
  // idles for a random gap. While idle the payload wanders, since only a valid
  // word means anything. Every call returns at a falling edge.
  task automatic send_word(input logic cmd, input logic [CODE_W-1:0] value,
                           input logic [CODE_LEN_W-1:0] len);
    int unsigned gap;
    in_valid       = 1'b1;
    in_command     = cmd;
    in_code_bits   = value;
    in_code_length = len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (cmd == CMD_RESTART) restarts_sent++;
    gap = (quiet_phase || back_to_back) ? 0 : pick_idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid       = 1'b0;
      in_command     = 1'($urandom_range(0, 1));
      in_code_bits   = CODE_W'($urandom);
      in_code_length = CODE_LEN_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Holds the input idle until every predicted byte has been received.
  task automatic drain_stream();
    in_valid = 1'b0;
    while (bytes_awaited != 0) @(negedge clk);
  endtask

  // Random word: mostly appends of legal length, some over-long lengths that
  // must saturate, a few restarts, and a bias toward all-ones codes so that
  // 0xFF bytes and their stuffed zeros come up often.
  task automatic send_random_word();
    logic [CODE_W-1:0]     value;
    logic [CODE_LEN_W-1:0] len;
    int unsigned           r;
    r     = $urandom_range(0, 99);
    value = ($urandom_range(0, 99) < 15) ? 16'hFFFF : CODE_W'($urandom);
    len   = ($urandom_range(0, 9) == 0) ? CODE_LEN_W'($urandom_range(17, 31))
                                       : CODE_LEN_W'($urandom_range(0, 16));
    if (r < 5) begin
      send_word(CMD_RESTART, value, len);
    end else begin
      send_word(CMD_APPEND, value, len);
    end
  endtask

  // Receiver: random stall bursts, a long hold-off on request, and no stalls
  // at all during the quiet phase. out_stall changes only at falling edges.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned free_left;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        out_stall = 1'b1;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
        out_stall = 1'b0;
      end else if (quiet_phase) begin
        out_stall = 1'b0;
      end else if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (free_left != 0) begin
        out_stall = 1'b0;
        free_left--;
      end else begin
        out_stall  = 1'b0;
        free_left  = $urandom_range(0, 10);
        stall_left = pick_idle_len();
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words. The comments track the bits left pending after each.
    send_word(CMD_APPEND,  16'hFFFF, 5'd0);   // zero length: nothing appended
    send_word(CMD_APPEND,  16'h0005, 5'd3);   // no whole byte yet, 3 pending
    send_word(CMD_RESTART, 16'hFFFF, 5'd31);  // restart, payload ignored
    send_word(CMD_APPEND,  16'h00FF, 5'd8);   // 0xFF then stuffed zero
    send_word(CMD_APPEND,  16'hFFFF, 5'd16);  // two 0xFF bytes, two stuffed zeros
    send_word(CMD_APPEND,  16'h007F, 5'd7);   // 7 ones pending
    send_word(CMD_APPEND,  16'hFFFF, 5'd16);  // four bytes out of one word
    send_word(CMD_APPEND,  16'h0001, 5'd1);   // completes another 0xFF
    send_word(CMD_APPEND,  16'hFFF5, 5'd4);   // bits above the length are dropped
    send_word(CMD_APPEND,  16'hA5C3, 5'd31);  // length saturates to sixteen
    send_word(CMD_APPEND,  16'h0000, 5'd17);  // saturated run of zeros
    send_word(CMD_APPEND,  16'h0000, 5'd16);
    send_word(CMD_RESTART, 16'h0000, 5'd0);
    send_word(CMD_APPEND,  16'h0ABC, 5'd12);  // 4 pending
    send_word(CMD_RESTART, 16'h1234, 5'd9);   // restart drops pending bits
    send_word(CMD_APPEND,  16'h8001, 5'd16);
    send_word(CMD_APPEND,  16'h001F, 5'd5);
    send_word(CMD_APPEND,  16'h0007, 5'd3);   // 0xFF built from two words
    send_word(CMD_APPEND,  16'h5555, 5'd20);
    send_word(CMD_APPEND,  16'h7FFF, 5'd15);
    send_word(CMD_APPEND,  16'h0002, 5'd2);
    send_word(CMD_APPEND,  16'h003F, 5'd6);
    send_word(CMD_APPEND,  16'hFFFE, 5'd16);

    // Random words with the pressure cases placed along the way.
    for (int i = 0; i < 300; i++) begin
      if (i == 60) begin
        // The receiver holds off while full-length words keep coming, so the
        // packer's queue fills and it must stall its input.
        rx_hold_cycles = 48;
        back_to_back   = 1'b1;
        for (int k = 0; k < 14; k++) begin
          send_word(CMD_APPEND, CODE_W'($urandom), 5'd16);
        end
        back_to_back = 1'b0;
      end
      if (i == 150) begin
        // The sender pauses until the whole stream so far has come out.
        drain_stream();
      end
      quiet_phase = (i >= 200 && i < 240);
      send_random_word();
    end
    quiet_phase = 1'b0;

    drain_stream();
    // Let any word that completes no byte settle through the packer as well.
    repeat (8) @(negedge clk);

    $display("Run covered %0d words (%0d restarts) and compared %0d stream bytes,",
             words_sent, restarts_sent, bytes_checked);
    $display("%0d of them stuffed zeros, with %0d mismatches.",
             stuffed_checked, mismatch_count);
    if (mismatch_count == 0 && bytes_awaited == 0) begin
      $display("jpeg_bit_packer_byte_stuffing_tb: clean");
    end else begin
      $display("jpeg_bit_packer_byte_stuffing_tb: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d bytes still expected.", bytes_awaited);
    $display("jpeg_bit_packer_byte_stuffing_tb: errors");
    $finish;
  end

endmodule
